### rtl/pcr_pkg.sv
// Shared types, code table and output alphabet for the five-bit repacker.
package pcr_pkg;

    localparam int GROUP_BITS = 5;

    typedef struct packed {
        logic       kind;
        logic [7:0] char_code;
    } item_t;

    typedef struct packed {
        logic [7:0] symbol;
        logic       has_symbol;
        logic       end_of_line;
        logic       run_last;
    } result_t;

    typedef struct packed {
        logic [7:0] bits;
        logic [3:0] len;
    } code_t;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_EOL  = 1'b1;

    // Prefix code per character; len of zero means not in the table.
    function automatic code_t code_lookup(input logic [7:0] ch);
        code_t c;
        c = '{bits: 8'h00, len: 4'd0};
        case (ch)
            8'h20: c = '{bits: 8'h05, len: 4'd3};
            8'h27: c = '{bits: 8'h00, len: 4'd6};
            8'h2C: c = '{bits: 8'h03, len: 4'd6};
            8'h2D: c = '{bits: 8'h91, len: 4'd8};
            8'h2E: c = '{bits: 8'h11, len: 4'd6};
            8'h3F: c = '{bits: 8'h01, len: 4'd6};
            8'h41: c = '{bits: 8'h25, len: 4'd6};
            8'h42: c = '{bits: 8'h9A, len: 4'd8};
            8'h43: c = '{bits: 8'h05, len: 4'd4};
            8'h44: c = '{bits: 8'h01, len: 4'd4};
            8'h45: c = '{bits: 8'h06, len: 4'd3};
            8'h46: c = '{bits: 8'h09, len: 4'd5};
            8'h47: c = '{bits: 8'h9B, len: 4'd8};
            8'h48: c = '{bits: 8'h10, len: 4'd6};
            8'h49: c = '{bits: 8'h07, len: 4'd4};
            8'h4A: c = '{bits: 8'h98, len: 4'd8};
            8'h4B: c = '{bits: 8'h06, len: 4'd4};
            8'h4C: c = '{bits: 8'h04, len: 4'd5};
            8'h4D: c = '{bits: 8'h99, len: 4'd8};
            8'h4E: c = '{bits: 8'h9E, len: 4'd8};
            8'h4F: c = '{bits: 8'h05, len: 4'd5};
            8'h50: c = '{bits: 8'h07, len: 4'd3};
            8'h51: c = '{bits: 8'h9F, len: 4'd8};
            8'h52: c = '{bits: 8'h08, len: 4'd4};
            8'h53: c = '{bits: 8'h06, len: 4'd5};
            8'h54: c = '{bits: 8'h07, len: 4'd5};
            8'h55: c = '{bits: 8'h9C, len: 4'd8};
            8'h56: c = '{bits: 8'h9D, len: 4'd8};
            8'h57: c = '{bits: 8'h02, len: 4'd6};
            8'h58: c = '{bits: 8'h92, len: 4'd8};
            8'h59: c = '{bits: 8'h93, len: 4'd8};
            8'h5A: c = '{bits: 8'h90, len: 4'd8};
            default: c = '{bits: 8'h00, len: 4'd0};
        endcase
        return c;
    endfunction

    // 5-bit group to output character: A..Z, then space . , - ' ?
    function automatic logic [7:0] group_char(input logic [4:0] g);
        logic [7:0] s;
        s = 8'h41 + {3'b000, g};
        case (g)
            5'd26:   s = 8'h20;
            5'd27:   s = 8'h2E;
            5'd28:   s = 8'h2C;
            5'd29:   s = 8'h2D;
            5'd30:   s = 8'h27;
            5'd31:   s = 8'h3F;
            default: s = 8'h41 + {3'b000, g};
        endcase
        return s;
    endfunction

endpackage

### rtl/prefix_code_five_bit_repacker.sv
// Top level: prefix-code characters repacked into 5-bit alphabet symbols.
//
//   channel  signals                         direction  payload
//   item     item_valid / item_ready / item  in         pcr_pkg::item_t
//   result   result_valid / result_ready     out        pcr_pkg::result_t
//
// A request is staged in an input register, decoded in one pass and any
// results (none, one or two) land in a two-entry result buffer. One item
// per cycle when it yields at most one result; after an item yielding two
// results, the next item waits until the single result port takes the
// second. Stalls on the result side back up through the buffer to
// item_ready. Reset clears the accumulator and all valid flags.
module prefix_code_five_bit_repacker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  pcr_pkg::item_t    item,
    output logic              result_valid,
    input  logic              result_ready,
    output pcr_pkg::result_t  result
);
    import pcr_pkg::*;

    logic       in_valid_reg, in_valid_next;
    item_t      in_item_reg;
    logic [3:0] pend_bits_reg, pend_bits_next;
    logic [2:0] pend_cnt_reg, pend_cnt_next;
    logic       head_valid_reg, head_valid_next;
    result_t    head_reg, head_next;
    logic       tail_valid_reg, tail_valid_next;
    result_t    tail_reg, tail_next;

    code_t      code;
    logic [11:0] acc;
    logic [3:0] total;
    logic [3:0] sh0, sh1;
    logic [4:0] g0, g1, geol;
    logic [1:0] n_res;
    logic [3:0] rem;
    logic [11:0] rem_mask;
    result_t    r0, r1;
    logic       slots_free, load, pop;

    assign pop        = head_valid_reg && result_ready;
    assign slots_free = !head_valid_reg || (result_ready && !tail_valid_reg);
    assign load       = in_valid_reg && slots_free;
    assign item_ready = !in_valid_reg || slots_free;

    assign result_valid = head_valid_reg;
    assign result       = head_reg;

    always_comb
    begin
        code  = code_lookup(in_item_reg.char_code);
        acc   = ({8'b0, pend_bits_reg} << code.len) | {4'b0, code.bits};
        total = {1'b0, pend_cnt_reg} + code.len;
        sh0   = total - 4'(GROUP_BITS);
        sh1   = total - 4'(2 * GROUP_BITS);
        g0    = 5'(acc >> sh0);
        g1    = 5'(acc >> sh1);
        geol  = 5'({1'b0, pend_bits_reg} << (3'(GROUP_BITS) - pend_cnt_reg));

        if (code.len == 4'd0)
        begin
            n_res = 2'd0;
            rem   = {1'b0, pend_cnt_reg};
        end
        else if (total >= 4'(2 * GROUP_BITS))
        begin
            n_res = 2'd2;
            rem   = sh1;
        end
        else if (total >= 4'(GROUP_BITS))
        begin
            n_res = 2'd1;
            rem   = sh0;
        end
        else
        begin
            n_res = 2'd0;
            rem   = total;
        end
        rem_mask = (12'd1 << rem) - 12'd1;

        r0 = '{symbol: group_char(g0), has_symbol: 1'b1, end_of_line: 1'b0,
               run_last: (n_res == 2'd1)};
        r1 = '{symbol: group_char(g1), has_symbol: 1'b1, end_of_line: 1'b0,
               run_last: 1'b1};

        pend_bits_next = pend_bits_reg;
        pend_cnt_next  = pend_cnt_reg;
        if (load)
        begin
            if (in_item_reg.kind == KIND_EOL)
            begin
                n_res = 2'd1;
                if (pend_cnt_reg != 3'd0)
                    r0 = '{symbol: group_char(geol), has_symbol: 1'b1,
                           end_of_line: 1'b1, run_last: 1'b1};
                else
                    r0 = '{symbol: 8'h00, has_symbol: 1'b0,
                           end_of_line: 1'b1, run_last: 1'b1};
                pend_bits_next = 4'd0;
                pend_cnt_next  = 3'd0;
            end
            else
            begin
                pend_bits_next = 4'(acc & rem_mask);
                pend_cnt_next  = 3'(rem);
            end
        end

        // result buffer: pop first, a load (only possible when room) overrides
        in_valid_next   = in_valid_reg;
        head_valid_next = head_valid_reg;
        head_next       = head_reg;
        tail_valid_next = tail_valid_reg;
        tail_next       = tail_reg;
        if (pop)
        begin
            if (tail_valid_reg)
            begin
                head_next       = tail_reg;
                tail_valid_next = 1'b0;
            end
            else
                head_valid_next = 1'b0;
        end
        if (load)
        begin
            in_valid_next = 1'b0;
            if (n_res != 2'd0)
            begin
                head_valid_next = 1'b1;
                head_next       = r0;
                tail_valid_next = (n_res == 2'd2);
                tail_next       = r1;
            end
        end
        if (item_valid && item_ready)
            in_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            head_valid_reg <= 1'b0;
            tail_valid_reg <= 1'b0;
            pend_bits_reg  <= 4'd0;
            pend_cnt_reg   <= 3'd0;
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            head_valid_reg <= head_valid_next;
            tail_valid_reg <= tail_valid_next;
            pend_bits_reg  <= pend_bits_next;
            pend_cnt_reg   <= pend_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
            in_item_reg <= item;
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule
